// ===== sv/psiq_pkg.sv =====
// Package: sizes and record type for the sorted insertion queue.
package psiq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int PRIO_PORT_W = 8;
    localparam int RECORD_W    = 32;
    localparam int PRIO_W      = (PRIORITY_BITS < PRIO_PORT_W) ? PRIORITY_BITS : PRIO_PORT_W;
    localparam int FILL_W      = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [RECORD_W-1:0] rec;
    } slot_entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== sv/psiq_cell.sv =====
// One slot of the sorted chain: compare against the new item, hold, take or shift.
module psiq_cell (
    input  logic                  clk,
    input  psiq_pkg::cell_ctrl_t  ctrl,
    input  logic                  occupied,
    input  psiq_pkg::slot_entry_t new_entry,
    input  psiq_pkg::slot_entry_t left_entry,
    input  logic                  left_keep,
    input  psiq_pkg::slot_entry_t right_entry,
    output psiq_pkg::slot_entry_t entry,
    output logic                  keep
);
    import psiq_pkg::*;

    slot_entry_t entry_reg;
    slot_entry_t entry_next;

    // strictly greater stays put: later arrivals go ahead of equals
    assign keep  = occupied && (entry_reg.prio > new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert && !keep)
        begin
            entry_next = left_keep ? new_entry : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/priority_sorted_insert_queue_unit.sv =====
// Top level: sorted insertion queue built from a chain of compare-and-shift cells.
// Latency: an item is inserted in the cycle it is taken; one item per cycle while collecting.
// After the item marked batch_end, the draining flag is set and the batch drains from cell 0
// through an output register, one item per cycle while out_ready takes each result.
// in_ready is low while draining; a new batch may start while the final item still waits.
// Reset (rst_n, asynchronous) empties the store and clears overflow_seen, not the output flag.
module priority_sorted_insert_queue_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [psiq_pkg::PRIO_PORT_W-1:0]  job_priority,
    input  logic [psiq_pkg::RECORD_W-1:0]     job_record,
    input  logic                              batch_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psiq_pkg::PRIO_PORT_W-1:0]  out_priority,
    output logic [psiq_pkg::RECORD_W-1:0]     out_record,
    output logic                              out_last,
    output logic                              overflow
);
    import psiq_pkg::*;

    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic              draining_reg, draining_next;
    logic              overflow_seen_reg, overflow_seen_next;
    logic              out_valid_reg, out_valid_next;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [RECORD_W-1:0] out_record_reg;
    logic                out_last_reg;
    logic                out_overflow_reg;

    logic        in_fire;
    logic        full;
    logic        out_load;
    logic        drain_done;
    cell_ctrl_t  ctrl;
    slot_entry_t new_entry;

    slot_entry_t cell_entry [CAPACITY];
    logic        cell_keep  [CAPACITY];

    assign in_ready   = !draining_reg;
    assign in_fire    = in_valid && in_ready;
    assign full       = (fill_count_reg == FILL_W'(CAPACITY));
    assign out_load   = draining_reg && (!out_valid_reg || out_ready);
    assign drain_done = out_load && (fill_count_reg == FILL_W'(1));

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_load;

    assign new_entry.prio = job_priority[PRIO_W-1:0];
    assign new_entry.rec  = job_record;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        slot_entry_t left_e;
        slot_entry_t right_e;
        logic        left_k;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = new_entry;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        psiq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (FILL_W'(i) < fill_count_reg),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        fill_count_next    = fill_count_reg;
        draining_next      = draining_reg;
        overflow_seen_next = overflow_seen_reg;
        out_valid_next     = out_valid_reg;

        if (ctrl.insert)
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end
        else if (out_load)
        begin
            fill_count_next = fill_count_reg - FILL_W'(1);
        end

        if (in_fire && full)
        begin
            overflow_seen_next = 1'b1;
        end
        else if (drain_done)
        begin
            overflow_seen_next = 1'b0;
        end

        if (in_fire && batch_end)
        begin
            draining_next = 1'b1;
        end
        else if (drain_done)
        begin
            draining_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg    <= '0;
            draining_reg      <= 1'b0;
            overflow_seen_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            fill_count_reg    <= fill_count_next;
            draining_reg      <= draining_next;
            overflow_seen_reg <= overflow_seen_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_prio_reg     <= cell_entry[0].prio;
            out_record_reg   <= cell_entry[0].rec;
            out_last_reg     <= (fill_count_reg == FILL_W'(1));
            out_overflow_reg <= overflow_seen_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_priority = PRIO_PORT_W'(out_prio_reg);
    assign out_record   = out_record_reg;
    assign out_last     = out_last_reg;
    assign overflow     = out_overflow_reg;

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (fill_count_reg != '0))
        else $error("draining with an empty store");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> (fill_count_reg == $past(fill_count_reg) + FILL_W'(1)))
        else $error("insert did not grow the store");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg >= FILL_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("head of store out of order");

endmodule
